/* rtl/rqa_pkg.sv */
// ----------------------------------------------------------------------------
// rqa_pkg: shared types and constants of the ready queue with aging
// Field widths, request and policy codes, the job record and the control
// word that the top level broadcasts to every queue cell.
// ----------------------------------------------------------------------------
package rqa_pkg;

  // Field widths
  localparam int unsigned ID_W     = 8;
  localparam int unsigned KEY_W    = 10;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned POL_W    = 3;
  localparam int unsigned JOB_W    = ID_W + 2 * KEY_W;
  localparam int unsigned TDATA_W  = ((JOB_W + 7) / 8) * 8;
  localparam int unsigned SUSER_W  = REQ_W;
  localparam int unsigned MUSER_W  = 3;

  // Default number of queue slots
  localparam int unsigned DEPTH_DEF = 16;

  // Result flag positions in the master-side tuser
  localparam int unsigned UBIT_VALID = 0;
  localparam int unsigned UBIT_EMPTY = 1;
  localparam int unsigned UBIT_DROP  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ   = 3'd0,
    REQ_REENQ = 3'd1,
    REQ_DEQ   = 3'd2,
    REQ_AGE   = 3'd3,
    REQ_FLUSH = 3'd4
  } req_e;

  typedef enum logic [POL_W-1:0] {
    POL_FCFS  = 3'd0,
    POL_RR    = 3'd1,
    POL_RR30  = 3'd2,
    POL_SJF   = 3'd3,
    POL_AGING = 3'd4
  } policy_e;

  // How a cell decides that the new job goes behind it
  typedef enum logic [1:0] {
    CMP_VALID, // append: every occupied cell stays ahead
    CMP_LEN,   // stable sort on length
    CMP_PRI,   // stable sort on priority
    CMP_NONE   // insert at the head
  } cmp_e;

  typedef enum logic [2:0] {
    COP_HOLD,
    COP_INSERT,
    COP_SHIFT,
    COP_AGE,
    COP_CLEAR
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  // Job record, id in the lowest bits
  typedef struct packed {
    logic [KEY_W-1:0] pri;
    logic [KEY_W-1:0] len;
    logic [ID_W-1:0]  id;
  } job_t;

  typedef struct packed {
    logic     cmp_en;
    cmp_e     cmp;
    cell_op_e op;
    job_t     job;
  } cell_ctrl_t;

endpackage

/* rtl/rqa_cell.sv */
// ----------------------------------------------------------------------------
// rqa_cell: one slot of the ready queue
// Holds one job and its occupied bit. Compares its key against the incoming
// job, passes the insertion chain to its right neighbor and takes data from
// either neighbor when the queue shifts.
// ----------------------------------------------------------------------------
module rqa_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rqa_pkg::cell_ctrl_t ctrl_i,
  input  rqa_pkg::job_t      left_job_i,
  input  logic               left_vld_i,
  input  rqa_pkg::job_t      right_job_i,
  input  logic               right_vld_i,
  input  logic               chain_i,
  output rqa_pkg::job_t      job_o,
  output logic               vld_o,
  output logic               chain_o
);

  rqa_pkg::job_t job_q, job_d;
  logic          vld_q, vld_d;
  logic          pass_q, pass_d;

  // Compare own key against the incoming job
  always_comb begin
    pass_d = pass_q;
    if (ctrl_i.cmp_en) begin
      unique case (ctrl_i.cmp)
        rqa_pkg::CMP_VALID: pass_d = vld_q;
        rqa_pkg::CMP_LEN:   pass_d = vld_q && (job_q.len <= ctrl_i.job.len);
        rqa_pkg::CMP_PRI:   pass_d = vld_q && (job_q.pri <= ctrl_i.job.pri);
        rqa_pkg::CMP_NONE:  pass_d = 1'b0;
        default:            pass_d = 1'b0;
      endcase
    end
  end

  // Keep the chain alive while every cell so far stays ahead of the new job
  assign chain_o = chain_i & pass_q;

  // Update the slot
  always_comb begin
    job_d = job_q;
    vld_d = vld_q;
    unique case (ctrl_i.op)
      rqa_pkg::COP_HOLD: ;
      rqa_pkg::COP_INSERT: begin
        if (chain_i && !pass_q) begin
          job_d = ctrl_i.job;
          vld_d = 1'b1;
        end else if (!chain_i) begin
          job_d = left_job_i;
          vld_d = left_vld_i;
        end
      end
      rqa_pkg::COP_SHIFT: begin
        job_d = right_job_i;
        vld_d = right_vld_i;
      end
      rqa_pkg::COP_AGE: begin
        if (vld_q && (job_q.pri != '0)) begin
          job_d.pri = job_q.pri - 1'b1;
        end
      end
      rqa_pkg::COP_CLEAR: vld_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pass_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      pass_q <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_o = job_q;
  assign vld_o = vld_q;

endmodule

/* rtl/ready_queue_with_aging_core.sv */
// ----------------------------------------------------------------------------
// ready_queue_with_aging_core: bounded scheduler ready queue with aging
// Top level: request sequencer, output register and the row of queue cells.
// ----------------------------------------------------------------------------
// Each request is handled as follows: in the cycle it is accepted every cell
// compares its stored key with the new job, and in the next cycle the
// insertion chain ripples through the row of cells and the cells shift,
// insert, age or clear while the result is loaded into the output register.
// A new request is taken once that result has left (or leaves in the same
// cycle), and never while a request is being applied. The slots hold no
// reset value and need no clearing pass; of the cell state only the occupied
// bits and the registered compare results reset. The policy register may be
// written at any time the block is idle.
module ready_queue_with_aging_core #(
  parameter int unsigned DEPTH = rqa_pkg::DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [7:0] job_id, [17:8] job_length, [27:18] job_priority, rest zero
  input  logic [rqa_pkg::TDATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  logic [rqa_pkg::SUSER_W-1:0]  s_axis_tuser,
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] out_id, [17:8] out_length, [27:18] out_priority, rest zero
  output logic [rqa_pkg::TDATA_W-1:0]  m_axis_tdata,
  // [0] out_valid, [1] queue_empty, [2] dropped
  output logic [rqa_pkg::MUSER_W-1:0]  m_axis_tuser,
  // Policy register write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rqa_pkg::POL_W-1:0]    cfg_data_i
);

  localparam int unsigned UBIT_VALID_IX = rqa_pkg::UBIT_VALID;
  localparam int unsigned UBIT_EMPTY_IX = rqa_pkg::UBIT_EMPTY;
  localparam int unsigned UBIT_DROP_IX  = rqa_pkg::UBIT_DROP;

  rqa_pkg::state_e     st_q, st_d;
  rqa_pkg::policy_e    pol_q;
  rqa_pkg::req_e       req_q, in_req;
  rqa_pkg::job_t       job_q, in_job;
  rqa_pkg::cell_ctrl_t ctrl;
  rqa_pkg::cmp_e       in_cmp;

  rqa_pkg::job_t       job_w [DEPTH];
  logic [DEPTH-1:0]    vld_w;
  logic [DEPTH:0]      chain_w;

  logic                        s_xfer;
  logic                        full;
  logic                        ins_ok;
  logic                        m_valid_q;
  logic [rqa_pkg::TDATA_W-1:0] m_data_q, m_data_d;
  logic [rqa_pkg::MUSER_W-1:0] m_user_q, m_user_d;

  assign in_req = rqa_pkg::req_e'(s_axis_tuser[rqa_pkg::REQ_W-1:0]);
  assign in_job = s_axis_tdata[rqa_pkg::JOB_W-1:0];
  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign full   = vld_w[DEPTH-1];
  assign ins_ok = ((req_q == rqa_pkg::REQ_ENQ) || (req_q == rqa_pkg::REQ_REENQ)) && !full;

  // Policy register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= rqa_pkg::POL_FCFS;
    end else if (cfg_valid_i) begin
      pol_q <= rqa_pkg::policy_e'(cfg_data_i);
    end
  end

  // Pick the insertion rule for the incoming request
  always_comb begin
    if ((in_req == rqa_pkg::REQ_REENQ) && (pol_q == rqa_pkg::POL_AGING)) begin
      if (vld_w[0] && (job_w[0].pri < in_job.pri)) begin
        in_cmp = rqa_pkg::CMP_PRI;
      end else begin
        in_cmp = rqa_pkg::CMP_NONE;
      end
    end else if (pol_q == rqa_pkg::POL_SJF) begin
      in_cmp = rqa_pkg::CMP_LEN;
    end else if (pol_q == rqa_pkg::POL_AGING) begin
      in_cmp = rqa_pkg::CMP_PRI;
    end else begin
      in_cmp = rqa_pkg::CMP_VALID;
    end
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      rqa_pkg::ST_IDLE:  if (s_xfer) st_d = rqa_pkg::ST_APPLY;
      rqa_pkg::ST_APPLY: st_d = rqa_pkg::ST_IDLE;
      default:           st_d = rqa_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and cell control
  always_comb begin
    s_axis_tready = 1'b0;
    ctrl.cmp_en   = 1'b0;
    ctrl.cmp      = in_cmp;
    ctrl.op       = rqa_pkg::COP_HOLD;
    ctrl.job      = job_q;
    unique case (st_q)
      rqa_pkg::ST_IDLE: begin
        // Compare against the offered job; the value at the transfer edge sticks
        s_axis_tready = !m_valid_q || m_axis_tready;
        ctrl.cmp_en   = 1'b1;
        ctrl.job      = in_job;
      end
      rqa_pkg::ST_APPLY: begin
        case (req_q)
          rqa_pkg::REQ_ENQ,
          rqa_pkg::REQ_REENQ: if (!full) ctrl.op = rqa_pkg::COP_INSERT;
          rqa_pkg::REQ_DEQ:   ctrl.op = rqa_pkg::COP_SHIFT;
          rqa_pkg::REQ_AGE:   ctrl.op = rqa_pkg::COP_AGE;
          rqa_pkg::REQ_FLUSH: ctrl.op = rqa_pkg::COP_CLEAR;
          default:            ctrl.op = rqa_pkg::COP_HOLD;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rqa_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      req_q <= in_req;
      job_q <= in_job;
    end
  end

  // Row of queue cells
  assign chain_w[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rqa_pkg::job_t left_job, right_job;
    logic          left_vld, right_vld;

    if (i == 0) begin : g_head
      assign left_job = '0;
      assign left_vld = 1'b0;
    end else begin : g_mid_l
      assign left_job = job_w[i-1];
      assign left_vld = vld_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_job = '0;
      assign right_vld = 1'b0;
    end else begin : g_mid_r
      assign right_job = job_w[i+1];
      assign right_vld = vld_w[i+1];
    end

    rqa_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_job_i  (left_job),
      .left_vld_i  (left_vld),
      .right_job_i (right_job),
      .right_vld_i (right_vld),
      .chain_i     (chain_w[i]),
      .job_o       (job_w[i]),
      .vld_o       (vld_w[i]),
      .chain_o     (chain_w[i+1])
    );
  end

  // Build the result
  always_comb begin
    m_data_d                = '0;
    m_user_d                = '0;
    m_user_d[UBIT_EMPTY_IX] = !vld_w[0];
    case (req_q)
      rqa_pkg::REQ_ENQ,
      rqa_pkg::REQ_REENQ: begin
        m_user_d[UBIT_DROP_IX]  = full;
        m_user_d[UBIT_EMPTY_IX] = 1'b0;
      end
      rqa_pkg::REQ_DEQ: begin
        if (vld_w[0]) begin
          m_data_d[rqa_pkg::JOB_W-1:0] = job_w[0];
          m_user_d[UBIT_VALID_IX]      = 1'b1;
        end
        m_user_d[UBIT_EMPTY_IX] = !vld_w[1];
      end
      rqa_pkg::REQ_FLUSH: m_user_d[UBIT_EMPTY_IX] = 1'b1;
      default: ;
    endcase
  end

  // Output register: load on apply, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (st_q == rqa_pkg::ST_APPLY) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == rqa_pkg::ST_APPLY) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Occupied cells always form a run from the head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, vld_w} + 1'b1))
    else $error("queue cells not contiguous from head");

  // Apply is always followed by idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == rqa_pkg::ST_APPLY) |=> (st_q == rqa_pkg::ST_IDLE))
    else $error("apply phase overran");

  // An accepted insert finds a free cell, so the chain ends inside the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == rqa_pkg::ST_APPLY) && ins_ok) |-> !chain_w[DEPTH])
    else $error("insertion point past the tail");

  // Insert grows the queue by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == rqa_pkg::ST_APPLY) && ins_ok)
      |=> ($countones(vld_w) == $past($countones(vld_w)) + 1))
    else $error("insert did not add one job");

  // Dequeue from a non-empty queue shrinks it by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == rqa_pkg::ST_APPLY) && (req_q == rqa_pkg::REQ_DEQ) && vld_w[0])
      |=> ($countones(vld_w) + 1 == $past($countones(vld_w))))
    else $error("dequeue did not remove one job");

endmodule
